// ===== sv/hpte_pkg.sv =====
// ----------------------------------------------------------------------------
// hpte_pkg: shared constants of the hashed page table engine
// Table geometry defaults, tag layout constants, request and outcome codes.
// ----------------------------------------------------------------------------
package hpte_pkg;

  // table geometry
  localparam int GROUPS_DEF = 1024;
  localparam int WAYS       = 8;

  // tag layout
  localparam int PIDBITS   = 21;
  localparam int COLBITS   = 2;
  localparam int COLOR_LSB = PIDBITS - COLBITS + 3 + 7;
  localparam logic [15:0] HASH_MASK = 16'hffff;

  // purge count saturates here
  localparam logic [13:0] COUNT_MAX = 14'h3fff;

  // request types
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_PURGE  = 1'b1;

  // result outcome codes
  localparam logic [1:0] OUT_MATCH = 2'd0;
  localparam logic [1:0] OUT_FREE  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_PURGE = 2'd3;

endpackage

// ===== sv/hpte_hash.sv =====
// ----------------------------------------------------------------------------
// hpte_hash: group hash and tag word of an insert request
// Builds the virtual segment id, the masked group hash and the valid tag.
// ----------------------------------------------------------------------------
module hpte_hash (
  input  logic [hpte_pkg::PIDBITS-1:0] space_id,
  input  logic [31:0]                  virt_addr,
  input  logic [9:0]                   group_mask,
  output logic [9:0]                   hash,
  output logic [31:0]                  tag
);
  import hpte_pkg::*;

  logic [23:0] vsid;
  logic [23:0] hash_full;

  // segment id: pid shifted by three, OR'd with the top address nibble
  assign vsid = {space_id, 3'b000} | {20'd0, virt_addr[31:28]};

  // hash over the page number bits, then the group mask
  assign hash_full = vsid ^ {8'd0, virt_addr[27:12] & HASH_MASK};
  assign hash      = hash_full[9:0] & group_mask;

  // valid bit, segment id, abbreviated page index
  assign tag = {1'b1, vsid, 1'b0, virt_addr[27:22]};

endmodule

// ===== sv/hashed_page_table_engine_unit.sv =====
// ----------------------------------------------------------------------------
// hashed_page_table_engine_unit: hashed page table insert and purge engine
// Tag and physical words live in single-port-write synchronous memories.
// ----------------------------------------------------------------------------
// After reset the block sweeps the tag memory to invalid, one entry a cycle;
// configuration writes are taken during the sweep but no request is. One
// request is worked at a time. An insert takes the request, reads the eight
// tags of the group through the registered tag memory port, writes the chosen
// slot and hands the result to the output register once that is free; when
// GROUPS is below 1024 a reciprocal-multiply remainder reduces the hash first.
// A purge reads every entry over the same port and clears those that match
// the color. The next request is taken as soon as the result is in the output
// register, whether or not it has been taken yet.
module hashed_page_table_engine_unit #(
  parameter int GROUPS = hpte_pkg::GROUPS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_req_type,
  input  logic [hpte_pkg::PIDBITS-1:0] in_space_id,
  input  logic [31:0]                  in_virt_addr,
  input  logic [31:0]                  in_phys_word,
  input  logic [hpte_pkg::COLBITS-1:0] in_purge_color,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [9:0]                   out_group_index,
  output logic [2:0]                   out_slot_index,
  output logic [1:0]                   out_outcome,
  output logic [13:0]                  out_purged_count,
  // group mask register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [9:0]                   cfg_data
);
  import hpte_pkg::*;

  localparam int ENTRIES  = GROUPS * WAYS;
  localparam int AW       = $clog2(ENTRIES);
  localparam bit NEED_MOD = GROUPS < 1024;
  localparam int GMOD     = NEED_MOD ? GROUPS : 1024;
  localparam logic [10:0] GMOD_W    = 11'(GMOD);
  // ceil(2^20 / GMOD): exact quotient for every 10-bit hash
  localparam logic [20:0] RECIP     = 21'((2**20 + GMOD - 1) / GMOD);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_MOD    = 8'b0000_0100,
    ST_SCAN   = 8'b0000_1000,
    ST_WRITE  = 8'b0001_0000,
    ST_PURGE  = 8'b0010_0000,
    ST_PDRAIN = 8'b0100_0000,
    ST_FIN    = 8'b1000_0000
  } state_t;

  // memories
  logic [31:0] tag_mem  [ENTRIES];
  logic [31:0] data_mem [ENTRIES];

  // control registers
  state_t        state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          pv_r, pv_nxt;
  logic [3:0]    scan_r, scan_nxt;
  logic [3:0]    mod_cnt_r, mod_cnt_nxt;
  logic          match_r, match_nxt;
  logic          free_r, free_nxt;
  logic [2:0]    ptr_r, ptr_nxt;
  logic [9:0]    mask_r, mask_nxt;
  logic          out_valid_r, out_valid_nxt;

  // datapath registers
  logic [AW-1:0] pa_d_r, pa_d_nxt;
  logic [2:0]    slot_r, slot_nxt;
  logic [1:0]    outcome_r, outcome_nxt;
  logic [9:0]    grp_r, grp_nxt;
  logic [9:0]    hsh_r, hsh_nxt;
  logic [9:0]    rem_r, rem_nxt;
  logic [31:0]   tag_r, tag_nxt;
  logic [31:0]   pw_r, pw_nxt;
  logic [1:0]    color_r, color_nxt;
  logic [13:0]   cnt_r, cnt_nxt;
  logic [31:0]   rd_data_r;
  logic [9:0]    o_grp_r, o_grp_nxt;
  logic [2:0]    o_slot_r, o_slot_nxt;
  logic [1:0]    o_out_r, o_out_nxt;
  logic [13:0]   o_cnt_r, o_cnt_nxt;

  // memory ports
  logic [AW-1:0] tag_raddr;
  logic          tag_we;
  logic [AW-1:0] tag_waddr;
  logic [31:0]   tag_wdata;
  logic          data_we;

  // hash of the incoming request
  logic [9:0]  in_hash;
  logic [31:0] in_tag;

  hpte_hash u_hash (
    .space_id   (in_space_id),
    .virt_addr  (in_virt_addr),
    .group_mask (mask_r),
    .hash       (in_hash),
    .tag        (in_tag)
  );

  // helpers
  logic        in_xfer;
  logic        out_free;
  logic [21:0] scan_full;
  logic [21:0] wr_full;
  logic [29:0] quo_full;
  logic [9:0]  qd_low;
  logic [2:0]  eval_k;
  logic [2:0]  slot_fin;
  logic [31:0] purge_sel;
  logic [31:0] purge_want;
  logic        purge_hit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign scan_full = {9'd0, grp_r, scan_r[2:0]};
  assign wr_full   = {9'd0, grp_r, slot_fin};
  assign eval_k    = 3'(scan_r - 4'd1);

  // hash remainder: quotient by reciprocal multiply, then subtract back
  assign quo_full = hsh_r * RECIP;
  assign qd_low   = 10'(rem_r * GMOD_W);

  // slot choice: matching tag, else first free, else round-robin
  always_comb begin
    if (match_r || free_r) begin
      slot_fin = slot_r;
    end else begin
      slot_fin = ptr_r;
    end
  end

  // purge selects valid entries whose top pid bits equal the color
  assign purge_sel  = 32'h8000_0000 | (32'd3 << COLOR_LSB);
  assign purge_want = 32'h8000_0000 | ({30'd0, color_r} << COLOR_LSB);
  assign purge_hit  = pv_r && ((rd_data_r & purge_sel) == purge_want);

  // next state and memory port control
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    pv_nxt        = pv_r;
    scan_nxt      = scan_r;
    mod_cnt_nxt   = mod_cnt_r;
    match_nxt     = match_r;
    free_nxt      = free_r;
    ptr_nxt       = ptr_r;
    mask_nxt      = mask_r;
    out_valid_nxt = out_valid_r;
    pa_d_nxt      = pa_d_r;
    slot_nxt      = slot_r;
    outcome_nxt   = outcome_r;
    grp_nxt       = grp_r;
    hsh_nxt       = hsh_r;
    rem_nxt       = rem_r;
    tag_nxt       = tag_r;
    pw_nxt        = pw_r;
    color_nxt     = color_r;
    cnt_nxt       = cnt_r;
    o_grp_nxt     = o_grp_r;
    o_slot_nxt    = o_slot_r;
    o_out_nxt     = o_out_r;
    o_cnt_nxt     = o_cnt_r;
    tag_raddr     = scan_full[AW-1:0];
    tag_we        = 1'b0;
    tag_waddr     = addr_r;
    tag_wdata     = '0;
    data_we       = 1'b0;

    // group mask register
    if (cfg_valid && cfg_ready) begin
      mask_nxt = cfg_data;
    end

    // result register drains on transfer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      // sweep every tag to invalid
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = addr_r;
        if (addr_r == LAST_ADDR) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      // take a request
      ST_IDLE: begin
        if (in_xfer) begin
          tag_nxt   = in_tag;
          pw_nxt    = in_phys_word;
          color_nxt = in_purge_color;
          if (in_req_type == REQ_PURGE) begin
            addr_nxt  = '0;
            pv_nxt    = 1'b0;
            cnt_nxt   = '0;
            state_nxt = ST_PURGE;
          end else if (NEED_MOD) begin
            hsh_nxt     = in_hash;
            rem_nxt     = '0;
            mod_cnt_nxt = '0;
            state_nxt   = ST_MOD;
          end else begin
            grp_nxt   = in_hash;
            scan_nxt  = '0;
            match_nxt = 1'b0;
            free_nxt  = 1'b0;
            slot_nxt  = '0;
            state_nxt = ST_SCAN;
          end
        end
      end

      // hash remainder by the group count: quotient, then remainder
      ST_MOD: begin
        if (mod_cnt_r == 4'd0) begin
          rem_nxt     = quo_full[29:20];
          mod_cnt_nxt = 4'd1;
        end else begin
          grp_nxt   = hsh_r - qd_low;
          scan_nxt  = '0;
          match_nxt = 1'b0;
          free_nxt  = 1'b0;
          slot_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end

      // read the eight tags; each is checked from the registered read data
      ST_SCAN: begin
        tag_raddr = scan_full[AW-1:0];
        if ((scan_r != 4'd0) && !match_r) begin
          if (rd_data_r == tag_r) begin
            match_nxt = 1'b1;
            slot_nxt  = eval_k;
          end else if (!free_r && !rd_data_r[31]) begin
            free_nxt = 1'b1;
            slot_nxt = eval_k;
          end
        end
        scan_nxt = scan_r + 4'd1;
        if (scan_r == 4'd8) begin
          state_nxt = ST_WRITE;
        end
      end

      // write the chosen slot
      ST_WRITE: begin
        tag_we    = 1'b1;
        data_we   = 1'b1;
        tag_waddr = wr_full[AW-1:0];
        tag_wdata = tag_r;
        slot_nxt  = slot_fin;
        if (match_r) begin
          outcome_nxt = OUT_MATCH;
        end else if (free_r) begin
          outcome_nxt = OUT_FREE;
        end else begin
          outcome_nxt = OUT_EVICT;
          ptr_nxt     = ptr_r + 3'd1;
        end
        cnt_nxt   = '0;
        state_nxt = ST_FIN;
      end

      // walk the table: read one entry, clear the one read before if it matches
      ST_PURGE: begin
        tag_raddr = addr_r;
        pv_nxt    = 1'b1;
        pa_d_nxt  = addr_r;
        if (purge_hit) begin
          tag_we    = 1'b1;
          tag_waddr = pa_d_r;
          if (cnt_r != COUNT_MAX) begin
            cnt_nxt = cnt_r + 14'd1;
          end
        end
        if (addr_r == LAST_ADDR) begin
          state_nxt = ST_PDRAIN;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end

      // last entry of the walk
      ST_PDRAIN: begin
        pv_nxt = 1'b0;
        if (purge_hit) begin
          tag_we    = 1'b1;
          tag_waddr = pa_d_r;
          if (cnt_r != COUNT_MAX) begin
            cnt_nxt = cnt_r + 14'd1;
          end
        end
        grp_nxt     = '0;
        slot_nxt    = '0;
        outcome_nxt = OUT_PURGE;
        state_nxt   = ST_FIN;
      end

      // hand the result to the output register
      ST_FIN: begin
        if (out_free) begin
          o_grp_nxt     = grp_r;
          o_slot_nxt    = slot_r;
          o_out_nxt     = outcome_r;
          o_cnt_nxt     = cnt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      pv_r        <= 1'b0;
      scan_r      <= '0;
      mod_cnt_r   <= '0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
      ptr_r       <= '0;
      mask_r      <= 10'h3ff;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      pv_r        <= pv_nxt;
      scan_r      <= scan_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      match_r     <= match_nxt;
      free_r      <= free_nxt;
      ptr_r       <= ptr_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pa_d_r    <= pa_d_nxt;
    slot_r    <= slot_nxt;
    outcome_r <= outcome_nxt;
    grp_r     <= grp_nxt;
    hsh_r     <= hsh_nxt;
    rem_r     <= rem_nxt;
    tag_r     <= tag_nxt;
    pw_r      <= pw_nxt;
    color_r   <= color_nxt;
    cnt_r     <= cnt_nxt;
    o_grp_r   <= o_grp_nxt;
    o_slot_r  <= o_slot_nxt;
    o_out_r   <= o_out_nxt;
    o_cnt_r   <= o_cnt_nxt;
  end

  // tag memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    rd_data_r <= tag_mem[tag_raddr];
  end

  // physical word memory, written with the tag on insert
  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[tag_waddr] <= pw_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_group_index  = o_grp_r;
  assign out_slot_index   = o_slot_r;
  assign out_outcome      = o_out_r;
  assign out_purged_count = o_cnt_r;

endmodule
